FILE: sv/assert_macros.svh
// Assertion macros used by the checker of the contrast stretch unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rcs_pkg.sv
// Shared types and constants of the RGB contrast stretch unit.
package rcs_pkg;

    // Default width of one colour channel inside the lanes.
    localparam int CHANNEL_BITS_DEF = 8;
    // Width of a colour field on the ports.
    localparam int PIX_BITS = 8;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_STRETCH = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                frame_start;
        logic [PIX_BITS-1:0] red_in;
        logic [PIX_BITS-1:0] green_in;
        logic [PIX_BITS-1:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_BITS-1:0] red_out;
        logic [PIX_BITS-1:0] green_out;
        logic [PIX_BITS-1:0] blue_out;
    } t_out_beat;

    // Commands from the top level to every lane.
    typedef struct packed {
        logic meas;
        logic restart;
        logic start;
        logic take;
    } t_lane_ctrl;

    // Status of one lane.
    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

endpackage

FILE: sv/rcs_lane.sv
// One colour channel: running minimum and maximum, and a restoring divider for the stretch.
module rcs_lane import rcs_pkg::*; #(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctrl              i_ctrl,
    input  logic [CHANNEL_BITS-1:0] i_value,
    output t_lane_stat              o_stat,
    output logic [CHANNEL_BITS-1:0] o_result
);

    localparam int W  = CHANNEL_BITS;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] CHAN_MAX = {W{1'b1}};

    typedef enum logic [1:0] {LANE_IDLE, LANE_RUN, LANE_DONE} t_lane_state;
    typedef enum logic [1:0] {MODE_PASS, MODE_ZERO, MODE_SAT, MODE_DIV} t_mode;

    t_lane_state r_state;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_low, r_high;
    t_mode         r_mode;
    logic [W-1:0]  r_value, r_div, r_rem, r_num, r_quo;

    logic [W-1:0]   base_low, base_high, n_low, n_high;
    logic [W-1:0]   offset;
    logic [2*W-1:0] scaled;
    logic [W:0]     rem_sh, rem_diff;
    logic           q_bit;
    t_mode          mode_sel;

    always_comb begin
        base_low  = i_ctrl.restart ? CHAN_MAX : r_low;
        base_high = i_ctrl.restart ? '0 : r_high;
        n_low     = (i_value < base_low)  ? i_value : base_low;
        n_high    = (i_value > base_high) ? i_value : base_high;
    end

    // Numerator (value - min) * (2^W - 1), formed as a shift and a subtract.
    always_comb begin
        offset = i_value - r_low;
        scaled = {offset, {W{1'b0}}} - {{W{1'b0}}, offset};
    end

    always_comb begin
        priority if (r_high <= r_low) begin
            mode_sel = MODE_PASS;
        end else if (i_value <= r_low) begin
            mode_sel = MODE_ZERO;
        end else if (i_value >= r_high) begin
            mode_sel = MODE_SAT;
        end else begin
            mode_sel = MODE_DIV;
        end
    end

    always_comb begin
        rem_sh   = {r_rem, r_num[W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        q_bit    = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LANE_IDLE;
            r_cnt   <= '0;
            r_low   <= CHAN_MAX;
            r_high  <= '0;
        end else begin
            if (i_ctrl.meas) begin
                r_low  <= n_low;
                r_high <= n_high;
            end
            unique case (r_state)
                LANE_IDLE: begin
                    if (i_ctrl.start) begin
                        r_mode  <= mode_sel;
                        r_value <= i_value;
                        r_div   <= r_high - r_low;
                        r_rem   <= scaled[2*W-1:W];
                        r_num   <= scaled[W-1:0];
                        r_quo   <= '0;
                        r_cnt   <= CW'(W);
                        r_state <= LANE_RUN;
                    end
                end
                LANE_RUN: begin
                    r_rem <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
                    r_num <= r_num << 1;
                    r_quo <= (r_quo << 1) | W'(q_bit);
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= LANE_DONE;
                    end
                end
                LANE_DONE: begin
                    if (i_ctrl.take) begin
                        r_state <= LANE_IDLE;
                    end
                end
                default: begin
                    r_state <= LANE_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_mode)
            MODE_PASS: o_result = r_value;
            MODE_ZERO: o_result = '0;
            MODE_SAT:  o_result = CHAN_MAX;
            MODE_DIV:  o_result = r_quo;
        endcase
    end

    assign o_stat.idle = (r_state == LANE_IDLE);
    assign o_stat.done = (r_state == LANE_DONE);

endmodule

FILE: sv/rcs_merge.sv
// Output stage: collects the three lane results into one registered output beat.
module rcs_merge import rcs_pkg::*; #(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_done,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    input  logic                    i_ready,
    output logic                    o_take,
    output logic                    o_valid,
    output t_out_beat               o_data
);

    logic      r_valid;
    t_out_beat r_data;

    assign o_take = i_done && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_valid          <= 1'b1;
                r_data.red_out   <= PIX_BITS'(i_red);
                r_data.green_out <= PIX_BITS'(i_green);
                r_data.blue_out  <= PIX_BITS'(i_blue);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/rgb_contrast_stretch_unit.sv
// Top level of the per-channel min-max RGB contrast stretch unit.
// The host streams each image twice. A measure beat (kind low) folds the pixel into a running
// minimum and maximum per channel, restarting them first when frame_start is set, and gives no
// output; measure beats may arrive on every clock while the lanes are idle. A stretch beat (kind
// high) maps each channel to (value - min) * (2^CHANNEL_BITS - 1) / (max - min), truncated and
// saturated, passing a channel unchanged when its maximum is not above its minimum. Three lanes,
// one per colour, each run a restoring divider that retires one quotient bit per cycle. A stretch
// beat closes the input while the lanes load, run their divider steps and move the results into
// the output register; the move waits while that register still holds an untaken result. The
// output register lets the next beat be accepted while a finished result waits to be taken.
module rgb_contrast_stretch_unit import rcs_pkg::*; #(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    localparam int W = CHANNEL_BITS;

    logic               in_accept;
    logic               take;
    t_lane_ctrl         lane_ctrl;
    t_lane_stat         lane_stat [3];
    logic [W-1:0]       lane_in   [3];
    logic [W-1:0]       lane_res  [3];

    // The input is taken only when every lane is free; the lanes move in lock step.
    assign o_ready   = lane_stat[0].idle && lane_stat[1].idle && lane_stat[2].idle;
    assign in_accept = i_valid && o_ready;

    assign lane_ctrl.meas    = in_accept && (i_data.kind == KIND_MEASURE);
    assign lane_ctrl.restart = i_data.frame_start;
    assign lane_ctrl.start   = in_accept && (i_data.kind == KIND_STRETCH);
    assign lane_ctrl.take    = take;

    // Port fields are resized to the lane width: truncated or zero-extended.
    assign lane_in[0] = W'(i_data.red_in);
    assign lane_in[1] = W'(i_data.green_in);
    assign lane_in[2] = W'(i_data.blue_in);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rcs_lane #(
            .CHANNEL_BITS(CHANNEL_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .i_value  (lane_in[g]),
            .o_stat   (lane_stat[g]),
            .o_result (lane_res[g])
        );
    end

    rcs_merge #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (lane_stat[0].done && lane_stat[1].done && lane_stat[2].done),
        .i_red   (lane_res[0]),
        .i_green (lane_res[1]),
        .i_blue  (lane_res[2]),
        .i_ready (i_ready),
        .o_take  (take),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

FILE: sv/rcs_checker.sv
// Port-level checker of the contrast stretch unit and its bind to the top level.
`include "assert_macros.svh"

module rcs_checker import rcs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_beat  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_beat o_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_data), "output beat changed while stalled")
    `ASSERT_NEXT(a_measure_free, i_clk, i_rst_n,
        i_valid && o_ready && (i_data.kind == KIND_MEASURE), o_ready,
        "measure beat blocked the input")
    `ASSERT_NEXT(a_stretch_busy, i_clk, i_rst_n,
        i_valid && o_ready && (i_data.kind == KIND_STRETCH), !o_ready,
        "input open during a stretch")
    `ASSERT_SAME(a_result_frees, i_clk, i_rst_n, $rose(o_valid), o_ready,
        "lanes not freed when a result appeared")

endmodule

bind rgb_contrast_stretch_unit rcs_checker u_rcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
